>>> hw/rtl/voi_pkg.sv
`timescale 1ns / 1ps

package voi_pkg;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int MAX_X      = 64;
    localparam int MAX_Y      = 64;
    localparam int MAX_Z      = 16;
    localparam int MAX_RADIUS = 7;

    localparam int REQ_W      = 2;
    localparam int PT_W       = 16;
    localparam int QX_W       = 6;
    localparam int QY_W       = 6;
    localparam int QZ_W       = 4;
    localparam int CNT_W      = 12;
    localparam int CPM_W      = 16;
    localparam int RADC_W     = 3;
    localparam int GXC_W      = 7;
    localparam int GYC_W      = 7;
    localparam int GZC_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 16;

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CPM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 3'd4;

    localparam int XI_W    = $clog2(MAX_X);
    localparam int YI_W    = $clog2(MAX_Y);
    localparam int ZI_W    = $clog2(MAX_Z);
    localparam int ROWS    = MAX_X * MAX_Y;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int MAX_DIM = max2(max2(MAX_X, MAX_Y), MAX_Z);
    localparam int SZ_W    = max2($clog2(MAX_DIM + 1), GXC_W);
    localparam int RAD_W   = max2($clog2(MAX_RADIUS + 1), RADC_W);
    localparam int ZC_W    = $clog2(MAX_Z + 1);
    localparam int PROD_W  = 2 * (PT_W + 1);
    localparam int CELL_W  = 18;

    typedef logic [MAX_Z-1:0] voi_row_t;

    typedef struct packed {
        logic [SZ_W-1:0]  sx;
        logic [SZ_W-1:0]  sy;
        logic [SZ_W-1:0]  sz;
        logic [RAD_W-1:0] rad;
    } voi_dims_t;

    typedef struct packed {
        logic            empty;
        logic [XI_W-1:0] x_lo;
        logic [XI_W-1:0] x_hi;
        logic [YI_W-1:0] y_lo;
        logic [YI_W-1:0] y_hi;
        logic [ZI_W-1:0] z_lo;
        logic [ZI_W-1:0] z_hi;
    } voi_box_t;

    function automatic logic [ROW_W-1:0] row_addr(input logic [XI_W-1:0] x,
                                                  input logic [YI_W-1:0] y);
        return ROW_W'(ROW_W'(x) * ROW_W'(MAX_Y)) + ROW_W'(y);
    endfunction

endpackage

>>> hw/rtl/voi_grid_mem.sv
`timescale 1ns / 1ps

module voi_grid_mem (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [voi_pkg::ROW_W-1:0]  waddr,
    input  voi_pkg::voi_row_t          wdata,
    input  logic                       re,
    input  logic [voi_pkg::ROW_W-1:0]  raddr,
    output voi_pkg::voi_row_t          rdata
);

    voi_pkg::voi_row_t mem [voi_pkg::ROWS];
    voi_pkg::voi_row_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/voi_coord_unit.sv
`timescale 1ns / 1ps

module voi_coord_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [voi_pkg::PT_W-1:0]   point_x,
    input  logic signed [voi_pkg::PT_W-1:0]   point_y,
    input  logic signed [voi_pkg::PT_W-1:0]   point_z,
    input  logic [voi_pkg::CPM_W-1:0]         cpm,
    input  voi_pkg::voi_dims_t                dims,
    output voi_pkg::voi_box_t                 box,
    output logic                              done
);

    localparam int PW = voi_pkg::PT_W;
    localparam int CW = voi_pkg::CELL_W;
    localparam int SW = voi_pkg::SZ_W;
    localparam int RW = voi_pkg::RAD_W;

    logic                          busy_reg;
    logic [2:0]                    step_reg;
    logic                          done_reg;
    logic signed [PW-1:0]          pt_reg [3];
    logic signed [voi_pkg::PROD_W-1:0] prod_reg;
    logic signed [CW-1:0]          cell_reg;
    logic signed [CW-1:0]          lo_reg [3];
    logic signed [CW-1:0]          hi_reg [3];
    logic [2:0]                    empty_reg;

    logic [1:0]                    mul_axis;
    logic [1:0]                    clip_axis;
    logic signed [PW:0]            mul_a;
    logic signed [PW:0]            mul_b;
    logic signed [voi_pkg::PROD_W-1:0] prod_next;
    logic                          prod_neg;
    logic [voi_pkg::PROD_W-1:0]    prod_mag;
    logic [voi_pkg::PROD_W-1:0]    prod_rnd;
    logic signed [CW-1:0]          cell_abs;
    logic signed [CW-1:0]          cell_next;
    logic [SW-1:0]                 size;
    logic signed [CW-1:0]          size_s;
    logic signed [CW-1:0]          rad_s;
    logic signed [CW-1:0]          center;
    logic signed [CW-1:0]          lo_raw;
    logic signed [CW-1:0]          hi_raw;
    logic signed [CW-1:0]          lo_clip;
    logic signed [CW-1:0]          hi_clip;

    always_comb begin
        mul_axis  = (step_reg[1:0] == 2'd3) ? 2'd2 : step_reg[1:0];
        clip_axis = 2'(step_reg - 3'd2);
        mul_a     = {pt_reg[mul_axis][PW-1], pt_reg[mul_axis]};
        mul_b     = {1'b0, cpm};
        prod_next = mul_a * mul_b;

        prod_neg  = prod_reg[voi_pkg::PROD_W-1];
        prod_mag  = prod_neg ? -prod_reg : prod_reg;
        prod_rnd  = prod_mag + voi_pkg::PROD_W'(32768);
        cell_abs  = $signed({{(CW-16){1'b0}}, prod_rnd[31:16]});
        cell_next = prod_neg ? -cell_abs : cell_abs;

        unique case (clip_axis)
            2'd0:    size = dims.sx;
            2'd1:    size = dims.sy;
            default: size = dims.sz;
        endcase
        size_s  = $signed({{(CW-SW){1'b0}}, size});
        rad_s   = $signed({{(CW-RW){1'b0}}, dims.rad});
        center  = cell_reg + (size_s >>> 1);
        lo_raw  = center - rad_s;
        hi_raw  = center + rad_s;
        lo_clip = (lo_raw < 0) ? '0 : lo_raw;
        hi_clip = (hi_raw > size_s - CW'(1)) ? size_s - CW'(1) : hi_raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            pt_reg[0] <= point_x;
            pt_reg[1] <= point_y;
            pt_reg[2] <= point_z;
        end
        if (busy_reg) begin
            prod_reg <= prod_next;
            cell_reg <= cell_next;
            if (step_reg >= 3'd2) begin
                lo_reg[clip_axis]    <= lo_clip;
                hi_reg[clip_axis]    <= hi_clip;
                empty_reg[clip_axis] <= (lo_clip > hi_clip);
            end
        end
    end

    always_comb begin
        box.empty = |empty_reg;
        box.x_lo  = voi_pkg::XI_W'(lo_reg[0]);
        box.x_hi  = voi_pkg::XI_W'(hi_reg[0]);
        box.y_lo  = voi_pkg::YI_W'(lo_reg[1]);
        box.y_hi  = voi_pkg::YI_W'(hi_reg[1]);
        box.z_lo  = voi_pkg::ZI_W'(lo_reg[2]);
        box.z_hi  = voi_pkg::ZI_W'(hi_reg[2]);
    end

    assign done = done_reg;

endmodule

>>> hw/rtl/voxel_occupancy_inflation.sv
`timescale 1ns / 1ps

// Occupancy grid of 64 x 64 x 16 voxels, stored as one 16-bit z column per (x, y) row.
// Requests arrive on the s_ channel: tuser selects clear, insert or query, tdata carries
// the point and the query index. Every request gives exactly one result item on m_.
// Registers are written through the cfg_ channel, which is always ready; write them only
// while no request is in flight.
// A clear sweeps the memory one row a cycle, from the first row to the last.
// An insert passes through the shared multiply/round/clip unit, then reads one (x, y) row
// of the clipped cube a cycle and writes each column back in a read-modify-write; its
// result goes to the output register after the last column write has drained.
// A query makes one registered read of its row, or none when it lies outside the grid.
// One request is worked on at a time; s_tready is low until its result is in the output
// register. That register holds the result while m_tready is low, and the next request
// is accepted meanwhile, but its result waits until the held one is taken.
// After reset the block clears the whole grid with s_tready low.
module voxel_occupancy_inflation (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // point_x, point_y, point_z, query_x, query_y, query_z
    input  logic [voi_pkg::S_TDATA_W-1:0]       s_tdata,
    // req_type
    input  logic [voi_pkg::REQ_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // occupied, newly_marked, zero fill
    output logic [voi_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [voi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [voi_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_COORD = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_QUERY = 3'd4;
    localparam logic [2:0] S_QWAIT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam int XW  = voi_pkg::XI_W;
    localparam int YW  = voi_pkg::YI_W;
    localparam int ZW  = voi_pkg::ZI_W;
    localparam int RWA = voi_pkg::ROW_W;
    localparam int SW  = voi_pkg::SZ_W;
    localparam int CNW = voi_pkg::CNT_W;

    logic [2:0]                      state_reg, state_next;
    logic                            clr_req_reg, clr_req_next;
    logic [RWA-1:0]                  clr_addr_reg, clr_addr_next;
    logic [XW-1:0]                   x_reg, x_next;
    logic [YW-1:0]                   y_reg, y_next;
    logic                            issue_done_reg, issue_done_next;
    logic                            p_valid_reg, p_valid_next;
    logic [RWA-1:0]                  p_addr_reg, p_addr_next;
    logic [CNW-1:0]                  cnt_reg, cnt_next;
    logic                            occ_reg, occ_next;
    logic [voi_pkg::QX_W-1:0]        qx_reg;
    logic [voi_pkg::QY_W-1:0]        qy_reg;
    logic [voi_pkg::QZ_W-1:0]        qz_reg;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            m_occ_reg;
    logic [CNW-1:0]                  m_cnt_reg;

    logic [voi_pkg::CPM_W-1:0]       cpm_reg;
    logic [voi_pkg::RADC_W-1:0]      radius_reg;
    logic [voi_pkg::GXC_W-1:0]       grid_x_reg;
    logic [voi_pkg::GYC_W-1:0]       grid_y_reg;
    logic [voi_pkg::GZC_W-1:0]       grid_z_reg;

    logic                            s_accept;
    logic                            m_load;
    logic                            coord_start;
    logic                            coord_done;
    voi_pkg::voi_box_t               box;
    voi_pkg::voi_dims_t              dims;
    logic                            grid_we;
    logic [RWA-1:0]                  grid_waddr;
    voi_pkg::voi_row_t               grid_wdata;
    logic                            grid_re;
    logic [RWA-1:0]                  grid_raddr;
    voi_pkg::voi_row_t               grid_rdata;
    voi_pkg::voi_row_t               z_mask;
    voi_pkg::voi_row_t               fresh;
    logic [voi_pkg::ZC_W-1:0]        fresh_cnt;
    logic                            q_in_range;

    always_comb begin
        dims.sx  = (SW'(grid_x_reg) > SW'(voi_pkg::MAX_X)) ? SW'(voi_pkg::MAX_X)
                                                            : SW'(grid_x_reg);
        dims.sy  = (SW'(grid_y_reg) > SW'(voi_pkg::MAX_Y)) ? SW'(voi_pkg::MAX_Y)
                                                            : SW'(grid_y_reg);
        dims.sz  = (SW'(grid_z_reg) > SW'(voi_pkg::MAX_Z)) ? SW'(voi_pkg::MAX_Z)
                                                            : SW'(grid_z_reg);
        dims.rad = (voi_pkg::RAD_W'(radius_reg) > voi_pkg::RAD_W'(voi_pkg::MAX_RADIUS))
                   ? voi_pkg::RAD_W'(voi_pkg::MAX_RADIUS) : voi_pkg::RAD_W'(radius_reg);
    end

    assign s_tready    = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign s_accept    = s_tvalid && s_tready;
    assign coord_start = s_accept && (s_tuser == voi_pkg::REQ_INSERT);

    voi_coord_unit u_coord (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (coord_start),
        .point_x ($signed(s_tdata[15:0])),
        .point_y ($signed(s_tdata[31:16])),
        .point_z ($signed(s_tdata[47:32])),
        .cpm     (cpm_reg),
        .dims    (dims),
        .box     (box),
        .done    (coord_done)
    );

    voi_grid_mem u_grid (
        .aclk  (aclk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .re    (grid_re),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    always_comb begin
        for (int i = 0; i < voi_pkg::MAX_Z; i++) begin
            z_mask[i] = (ZW'(i) >= box.z_lo) && (ZW'(i) <= box.z_hi);
        end
        fresh     = z_mask & ~grid_rdata;
        fresh_cnt = '0;
        for (int i = 0; i < voi_pkg::MAX_Z; i++) begin
            fresh_cnt = fresh_cnt + voi_pkg::ZC_W'(fresh[i]);
        end
        q_in_range = (SW'(qx_reg) < dims.sx) && (SW'(qy_reg) < dims.sy)
                     && (SW'(qz_reg) < dims.sz);
    end

    always_comb begin
        state_next      = state_reg;
        clr_req_next    = clr_req_reg;
        clr_addr_next   = clr_addr_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        issue_done_next = issue_done_reg;
        p_valid_next    = 1'b0;
        cnt_next        = cnt_reg;
        occ_next        = occ_reg;
        m_load          = 1'b0;
        grid_we         = 1'b0;
        grid_waddr      = p_addr_reg;
        grid_wdata      = grid_rdata | z_mask;
        grid_re         = 1'b0;
        grid_raddr      = voi_pkg::row_addr(x_reg, y_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    cnt_next = '0;
                    occ_next = 1'b0;
                    unique case (s_tuser)
                        voi_pkg::REQ_CLEAR: begin
                            state_next    = S_CLEAR;
                            clr_req_next  = 1'b1;
                            clr_addr_next = '0;
                        end
                        voi_pkg::REQ_INSERT: state_next = S_COORD;
                        voi_pkg::REQ_QUERY:  state_next = S_QUERY;
                        default:             state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = clr_addr_reg;
                grid_wdata = '0;
                if (clr_addr_reg == RWA'(voi_pkg::ROWS - 1)) begin
                    state_next = clr_req_reg ? S_DONE : S_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + RWA'(1);
                end
            end
            S_COORD: begin
                if (coord_done) begin
                    if (box.empty) begin
                        state_next = S_DONE;
                    end else begin
                        state_next      = S_MARK;
                        x_next          = box.x_lo;
                        y_next          = box.y_lo;
                        issue_done_next = 1'b0;
                    end
                end
            end
            S_MARK: begin
                if (!issue_done_reg) begin
                    grid_re      = 1'b1;
                    p_valid_next = 1'b1;
                    if (y_reg == box.y_hi) begin
                        y_next = box.y_lo;
                        if (x_reg == box.x_hi) begin
                            issue_done_next = 1'b1;
                        end else begin
                            x_next = x_reg + XW'(1);
                        end
                    end else begin
                        y_next = y_reg + YW'(1);
                    end
                end
                if (p_valid_reg) begin
                    grid_we  = 1'b1;
                    cnt_next = cnt_reg + CNW'(fresh_cnt);
                end
                if (issue_done_reg && !p_valid_reg) begin
                    state_next = S_DONE;
                end
            end
            S_QUERY: begin
                if (q_in_range) begin
                    grid_re    = 1'b1;
                    grid_raddr = voi_pkg::row_addr(XW'(qx_reg), YW'(qy_reg));
                    state_next = S_QWAIT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_QWAIT: begin
                occ_next   = grid_rdata[ZW'(qz_reg)];
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_load     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        p_addr_next = grid_raddr;

        if (m_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_req_reg  <= 1'b0;
            clr_addr_reg <= '0;
            p_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_req_reg  <= clr_req_next;
            clr_addr_reg <= clr_addr_next;
            p_valid_reg  <= p_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        issue_done_reg <= issue_done_next;
        p_addr_reg     <= p_addr_next;
        cnt_reg        <= cnt_next;
        occ_reg        <= occ_next;
        if (s_accept) begin
            qx_reg <= s_tdata[53:48];
            qy_reg <= s_tdata[59:54];
            qz_reg <= s_tdata[63:60];
        end
        if (m_load) begin
            m_occ_reg <= occ_reg;
            m_cnt_reg <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpm_reg    <= 16'd2560;
            radius_reg <= 3'd2;
            grid_x_reg <= 7'd64;
            grid_y_reg <= 7'd64;
            grid_z_reg <= 5'd16;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                voi_pkg::REG_CPM:    cpm_reg    <= cfg_data;
                voi_pkg::REG_RADIUS: radius_reg <= cfg_data[voi_pkg::RADC_W-1:0];
                voi_pkg::REG_GRID_X: grid_x_reg <= cfg_data[voi_pkg::GXC_W-1:0];
                voi_pkg::REG_GRID_Y: grid_y_reg <= cfg_data[voi_pkg::GYC_W-1:0];
                voi_pkg::REG_GRID_Z: grid_z_reg <= cfg_data[voi_pkg::GZC_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(voi_pkg::M_TDATA_W - CNW - 1){1'b0}}, m_cnt_reg, m_occ_reg};

    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        grid_we |-> (state_reg == S_CLEAR || state_reg == S_MARK))
        else $error("grid written outside a clear sweep or an insert");

    a_coord_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        coord_done |-> (state_reg == S_COORD))
        else $error("coordinate unit finished while no insert waits for it");

    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !p_valid_reg)
        else $error("ready while a column update is still in flight");

    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && (m_tdata[CNW:1] != '0)))
        else $error("result carries both an occupied bit and a mark count");

endmodule
